/* rtl/pbad_pkg.sv */
package pbad_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 152;
  localparam int CFG_DATA_W  = 64;

  localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;
  localparam logic [31:0] BAR_ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] BAR_FLAG_MASK = 32'hFFFF_FFF0;

  localparam logic REQ_PROBE = 1'b0;
  localparam logic REQ_FIND  = 1'b1;

  localparam logic CFG_MMIO_BASE = 1'b0;
  localparam logic CFG_IRQ_BASE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_ABSENT    = 3'd0,
    STAT_RECORDED  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_ALIGN,
    ST_ADVANCE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // one table slot
  typedef struct packed {
    logic [31:0] ids;
    logic [15:0] loc;
    logic [15:0] cls;
    logic [63:0] bar;
    logic [9:0]  irq;
  } entry_t;

  // result transaction, first field in the highest bits
  typedef struct packed {
    logic [9:0]  irq_num;
    logic [31:0] bar_size;
    logic [63:0] bar_base;
    logic [7:0]  subclass_code;
    logic [7:0]  base_class;
    logic [2:0]  func_out;
    logic [4:0]  dev_out;
    logic [7:0]  bus_out;
    logic [4:0]  entry_index;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic calc;
    logic align;
    logic advance;
  } alloc_ctl_t;

endpackage

/* rtl/pbad_entry_mem.sv */
module pbad_entry_mem (
  input  logic                    clk,
  input  logic                    we,
  input  logic [pbad_pkg::IDX_W-1:0] waddr,
  input  pbad_pkg::entry_t        wdata,
  input  logic [pbad_pkg::IDX_W-1:0] raddr,
  output pbad_pkg::entry_t        rdata
);
  import pbad_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pbad_bar_alloc.sv */
module pbad_bar_alloc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 base_we,
  input  logic [63:0]          base_value,
  input  pbad_pkg::alloc_ctl_t ctl,
  input  logic [31:0]          bar_readback,
  output logic [63:0]          bar_base,
  output logic [31:0]          bar_size
);
  import pbad_pkg::*;

  logic [63:0] next_addr_r;
  logic [63:0] next_addr_nxt;
  logic [31:0] size_r;
  logic [63:0] size_m1_r;
  logic        has_bar_r;
  logic [63:0] bar_r;
  logic [31:0] flag_cleared;
  logic [63:0] aligned;

  assign flag_cleared = bar_readback & BAR_FLAG_MASK;
  assign aligned      = (next_addr_r + size_m1_r) & ~size_m1_r;

  always_comb begin
    next_addr_nxt = next_addr_r;
    if (base_we) begin
      next_addr_nxt = base_value;
    end else if (ctl.advance && has_bar_r) begin
      next_addr_nxt = bar_r + {32'd0, size_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_addr_r <= '0;
    end else begin
      next_addr_r <= next_addr_nxt;
    end
  end

  // size - 1 is ~m when the size is nonzero; a zero size masks everything off
  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      has_bar_r <= (bar_readback != 32'd0) && (bar_readback != BAR_ALL_ONES);
      size_r    <= ((bar_readback != 32'd0) && (bar_readback != BAR_ALL_ONES)) ?
                   (~flag_cleared + 32'd1) : 32'd0;
      size_m1_r <= (flag_cleared == 32'd0) ? {64{1'b1}} : {32'd0, ~flag_cleared};
    end
    if (ctl.align) begin
      bar_r <= has_bar_r ? aligned : 64'd0;
    end
  end

  assign bar_base = bar_r;
  assign bar_size = size_r;

endmodule

/* rtl/pci_bar_allocator_device_table.sv */
// Probe transactions (tuser 0) size BAR0 from its all-ones readback, take the
// aligned address from a bump pointer that starts at mmio_base, and record the
// function, while a slot is free, in a 32-slot table held in a single-port-read
// synchronous RAM. An absent function goes straight to its result; a probe
// steps through the size, align and advance states. Find transactions (tuser 1)
// walk the recorded slots through the registered RAM read port, one slot per
// cycle. The next transaction is taken while a finished result waits on the
// output register. Writing mmio_base reloads the allocation pointer; the table
// has no clearing pass after reset.
module pci_bar_allocator_device_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [pbad_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // bus_num, dev_num, func_num, vendor, device, class_word, bar_readback
  input  logic [pbad_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status, entry_index, bus_out, dev_out, func_out, base_class,
  // subclass_code, bar_base, bar_size, irq_num, zero pad
  output logic [pbad_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import pbad_pkg::*;

  state_t      state_r, state_nxt;
  alloc_ctl_t  alloc_ctl;
  logic        in_acc;
  logic        out_free;
  logic        out_load;

  logic [9:0]  irq_base_r;
  logic [CNT_W-1:0] cnt_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     out_r;

  logic        req_r;
  logic [7:0]  bus_r;
  logic [4:0]  dev_r;
  logic [2:0]  fn_r;
  logic [31:0] ids_r;
  logic [15:0] cls_r;
  logic [31:0] mask_r;

  logic [CNT_W-1:0] idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic        pend_r;
  logic        hit;
  logic        more;
  logic        full;
  logic [9:0]  irq_calc;

  logic        mem_we;
  entry_t      wentry;
  entry_t      rentry;
  logic [63:0] alloc_bar;
  logic [31:0] alloc_size;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign hit      = pend_r && (rentry.ids == ids_r);
  assign more     = idx_r < cnt_r;
  assign full     = cnt_r == CNT_W'(TABLE_DEPTH);
  assign irq_calc = irq_base_r + {8'd0, dev_r[1:0]};

  pbad_bar_alloc u_alloc (
    .clk          (clk),
    .rst_n        (rst_n),
    .base_we      (cfg_we && (cfg_index == CFG_MMIO_BASE)),
    .base_value   (cfg_wdata),
    .ctl          (alloc_ctl),
    .bar_readback (mask_r),
    .bar_base     (alloc_bar),
    .bar_size     (alloc_size)
  );

  assign wentry = '{ids: ids_r, loc: {bus_r, dev_r, fn_r}, cls: cls_r,
                    bar: alloc_bar, irq: irq_calc};

  // writes only happen on probes and reads only on finds, so no forwarding
  pbad_entry_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (wentry),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rentry)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == REQ_FIND) begin
            state_nxt = ST_SEARCH;
          end else if (in_tdata[31:16] == VENDOR_ABSENT) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SIZE;
          end
        end
      end
      ST_SIZE:    state_nxt = ST_ALIGN;
      ST_ALIGN:   state_nxt = ST_ADVANCE;
      ST_ADVANCE: state_nxt = ST_DONE;
      ST_SEARCH: begin
        if (hit || !more) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    alloc_ctl = '0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_SIZE:    alloc_ctl.calc = 1'b1;
      ST_ALIGN:   alloc_ctl.align = 1'b1;
      ST_ADVANCE: begin
        alloc_ctl.advance = 1'b1;
        mem_we            = !full;
      end
      ST_DONE:    out_load = out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      irq_base_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && !out_tready) || out_load;
      if (cfg_we && (cfg_index == CFG_IRQ_BASE)) begin
        irq_base_r <= cfg_wdata[9:0];
      end
      if (mem_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (in_acc) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
      end else if (state_r == ST_SEARCH) begin
        // one read in flight; the compare works on the address issued the cycle before
        pend_r <= more && !hit;
        if (more && !hit) begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_tuser;
      bus_r  <= in_tdata[7:0];
      dev_r  <= in_tdata[12:8];
      fn_r   <= in_tdata[15:13];
      ids_r  <= {in_tdata[31:16], in_tdata[47:32]};
      cls_r  <= in_tdata[79:64];
      mask_r <= in_tdata[111:80];
      res_r  <= '0;
    end
    if (state_r == ST_SEARCH) begin
      cmp_idx_r <= idx_r[IDX_W-1:0];
      if (hit) begin
        res_r.status        <= STAT_FOUND;
        res_r.entry_index   <= 5'(cmp_idx_r);
        res_r.bus_out       <= rentry.loc[15:8];
        res_r.dev_out       <= rentry.loc[7:3];
        res_r.func_out      <= rentry.loc[2:0];
        res_r.base_class    <= rentry.cls[15:8];
        res_r.subclass_code <= rentry.cls[7:0];
        res_r.bar_base      <= rentry.bar;
        res_r.bar_size      <= '0;
        res_r.irq_num       <= rentry.irq;
      end else if (!more) begin
        // the rest of the result was cleared when the find was taken
        res_r.status <= STAT_NOT_FOUND;
      end
    end
    if (state_r == ST_ADVANCE) begin
      res_r.status        <= full ? STAT_FULL : STAT_RECORDED;
      res_r.entry_index   <= full ? 5'd0 : 5'(cnt_r[IDX_W-1:0]);
      res_r.bus_out       <= bus_r;
      res_r.dev_out       <= dev_r;
      res_r.func_out      <= fn_r;
      res_r.base_class    <= cls_r[15:8];
      res_r.subclass_code <= cls_r[7:0];
      res_r.bar_base      <= alloc_bar;
      res_r.bar_size      <= alloc_size;
      res_r.irq_num       <= irq_calc;
    end
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("table write without count advance");

  a_write_probe: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (req_r == REQ_PROBE) && (ids_r[31:16] != VENDOR_ABSENT))
    else $error("table written outside a present-function probe");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (res_r.status == STAT_FOUND) |-> CNT_W'(res_r.entry_index) < cnt_r)
    else $error("match reported beyond recorded slots");

  a_search_idle_port: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> !in_tready && !mem_we)
    else $error("input or table write during search");

endmodule
